// ===== hdl/tsf_pkg.sv =====
`timescale 1ns / 1ps

package tsf_pkg;

    // Default build values.
    localparam int SAMPLES_PER_AXIS_DEF = 15;
    localparam int TRIM_EACH_END_DEF    = 5;
    localparam int SAMPLE_BITS_DEF      = 12;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_VALID   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGREE_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE     = 3'd5;

    localparam int RAW_W    = 12;
    localparam int SCALE_W  = 16;
    localparam int SCREEN_W = 16;

    localparam logic [RAW_W-1:0]   MIN_VALID_RST   = 12'd100;
    localparam logic [RAW_W-1:0]   AGREE_RANGE_RST = 12'd20;
    localparam logic [RAW_W-1:0]   X_OFFSET_RST    = 12'd449;
    localparam logic [RAW_W-1:0]   Y_OFFSET_RST    = 12'd3962;
    localparam logic [SCALE_W-1:0] X_SCALE_RST     = 16'd13178;
    localparam logic [SCALE_W-1:0] Y_SCALE_RST     = 16'd11304;

    localparam int SCREEN_UNITS = 1000;
    localparam int UNITS_W      = 10;

    // Position in the four-group cycle.
    localparam logic [1:0] GRP_FIRST_X  = 2'd0;
    localparam logic [1:0] GRP_FIRST_Y  = 2'd1;
    localparam logic [1:0] GRP_SECOND_X = 2'd2;
    localparam logic [1:0] GRP_SECOND_Y = 2'd3;

    typedef enum logic [3:0] {
        ST_ACCEPT,
        ST_DRAIN,
        ST_MEAN,
        ST_DECIDE,
        ST_X_GO,
        ST_X_WAIT,
        ST_Y_GO,
        ST_Y_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;    // a word is being inserted this cycle
        logic shift;   // chain moves one place toward the tail
        logic below;   // cell index is below the insert position
        logic at_pos;  // cell index equals the insert position
    } t_cell_ctl;

endpackage

// ===== hdl/tsf_cell.sv =====
`timescale 1ns / 1ps

module tsf_cell #(
    parameter int SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  tsf_pkg::t_cell_ctl     i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [SAMPLE_BITS-1:0] i_left_val,
    input  logic                   i_left_gt,
    output logic [SAMPLE_BITS-1:0] o_val,
    output logic                   o_gt
);

    logic [SAMPLE_BITS-1:0] r_val;

    // Only cells already filled in this group take part in the compare.
    assign o_gt  = i_ctl.below && (r_val > i_sample);
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_val <= i_left_val;
        end else if (i_ctl.load && (i_ctl.below || i_ctl.at_pos)) begin
            if (i_left_gt) begin
                r_val <= i_left_val;
            end else if (o_gt || i_ctl.at_pos) begin
                r_val <= i_sample;
            end
        end
    end

endmodule

// ===== hdl/tsf_div.sv =====
`timescale 1ns / 1ps

module tsf_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = tsf_pkg::SCALE_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic             w_bit;
    logic [DEN_W:0]   w_rem_next;

    // Restoring division, one quotient bit per cycle. A zero divisor gives all ones.
    assign w_trial    = {r_rem[DEN_W-1:0], r_quo[NUM_W-1]};
    assign w_bit      = w_trial >= {1'b0, r_den};
    assign w_rem_next = w_bit ? (w_trial - {1'b0, r_den}) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_rem_next;
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== hdl/touch_sample_trimmed_mean_filter.sv =====
`timescale 1ns / 1ps

// Trimmed-mean touch filter. Samples enter one per cycle, when not stalled, into an
// insertion chain that keeps the current group sorted. After the last sample of a group
// the input stalls while the chain drains through an adder, then the MEAN state turns the
// sum into the mean with a reciprocal multiply and the DECIDE state makes the decision. A
// rejected reading passes through the EMIT state to load the output register. When the
// second Y group ends with an agreeing pair, a bit-serial divider computes the X and then
// the Y screen coordinate, and the EMIT state loads the result. A pending result waits in
// the output register without blocking new samples; only the next result to be loaded
// waits for it to be taken.
module touch_sample_trimmed_mean_filter #(
    parameter int SAMPLES_PER_AXIS = tsf_pkg::SAMPLES_PER_AXIS_DEF,
    parameter int TRIM_EACH_END    = tsf_pkg::TRIM_EACH_END_DEF,
    parameter int SAMPLE_BITS      = tsf_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [tsf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [SAMPLE_BITS-1:0]          i_sample,
    input  logic                            i_restart,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_accepted,
    output logic [tsf_pkg::RAW_W-1:0]       o_x_raw,
    output logic [tsf_pkg::RAW_W-1:0]       o_y_raw,
    output logic [tsf_pkg::SCREEN_W-1:0]    o_x_screen,
    output logic [tsf_pkg::SCREEN_W-1:0]    o_y_screen
);

    localparam int N       = SAMPLES_PER_AXIS;
    localparam int B       = SAMPLE_BITS;
    localparam int PW      = $clog2(N);
    localparam int SUM_W   = B + $clog2(N + 1);
    localparam int CW      = (B > tsf_pkg::RAW_W) ? B : tsf_pkg::RAW_W;
    localparam int NUM_W   = CW + tsf_pkg::UNITS_W;
    localparam int MID_CNT = (2 * TRIM_EACH_END >= N) ? 1 : N - 2 * TRIM_EACH_END;

    // The shift is wide enough that the reciprocal multiply gives the exact
    // truncated quotient for every sum that fits in SUM_W bits.
    localparam int MUL_W   = SUM_W + 1;
    localparam int PROD_W  = SUM_W + MUL_W;
    localparam int MEAN_SH = SUM_W + $clog2(MID_CNT);
    localparam logic [MUL_W-1:0] MEAN_MUL =
        MUL_W'(((longint'(1) << MEAN_SH) + longint'(MID_CNT) - 1) / longint'(MID_CNT));

    // Configuration.
    logic [tsf_pkg::RAW_W-1:0]   r_min_valid;
    logic [tsf_pkg::RAW_W-1:0]   r_agree_range;
    logic [tsf_pkg::RAW_W-1:0]   r_x_offset;
    logic [tsf_pkg::RAW_W-1:0]   r_y_offset;
    logic [tsf_pkg::SCALE_W-1:0] r_x_scale;
    logic [tsf_pkg::SCALE_W-1:0] r_y_scale;

    tsf_pkg::t_state r_state, n_state;

    logic [PW-1:0]    r_pos;
    logic [1:0]       r_group;
    logic [PW-1:0]    r_drn;
    logic [SUM_W-1:0] r_sum;
    logic [B-1:0]     r_mean;
    logic [B-1:0]     r_held_x;
    logic [B-1:0]     r_first_x;
    logic [B-1:0]     r_first_y;

    // Result staging and output register.
    logic                          r_ok;
    logic [B-1:0]                  r_xr;
    logic [B-1:0]                  r_yr;
    logic [tsf_pkg::SCREEN_W-1:0]  r_xs;
    logic [tsf_pkg::SCREEN_W-1:0]  r_ys;
    logic                          r_o_valid;
    logic                          r_o_accepted;
    logic [tsf_pkg::RAW_W-1:0]     r_o_x_raw;
    logic [tsf_pkg::RAW_W-1:0]     r_o_y_raw;
    logic [tsf_pkg::SCREEN_W-1:0]  r_o_x_screen;
    logic [tsf_pkg::SCREEN_W-1:0]  r_o_y_screen;

    logic            w_in_acc;
    logic            w_out_acc;
    logic [PW-1:0]   w_eff_pos;
    logic [1:0]      w_eff_group;
    logic            w_last_pos;
    logic            w_emit_load;

    logic [B-1:0]    w_val [N];
    logic            w_gt  [N];

    logic [PROD_W-1:0]            w_mean_prod;

    logic                         w_div_start;
    logic [NUM_W-1:0]             w_div_num;
    logic [tsf_pkg::SCALE_W-1:0]  w_div_den;
    logic                         w_div_busy;
    logic                         w_div_done;
    logic [NUM_W-1:0]             w_div_quot;
    logic [tsf_pkg::SCREEN_W-1:0] w_div_sat;

    logic            w_low;
    logic            w_far;
    logic [B-1:0]    w_dx;
    logic [B-1:0]    w_dy;
    logic [B:0]      w_x_sum;
    logic [B:0]      w_y_sum;
    logic [CW-1:0]   w_raw_sel;
    logic [CW-1:0]   w_off_sel;
    logic [CW-1:0]   w_dist;
    logic            w_in_window;

    assign w_in_acc    = i_valid && !o_stall;
    assign w_out_acc   = r_o_valid && !i_stall;
    assign w_eff_pos   = i_restart ? '0 : r_pos;
    assign w_eff_group = i_restart ? tsf_pkg::GRP_FIRST_X : r_group;
    assign w_last_pos  = (w_eff_pos == PW'(N - 1));
    assign o_stall     = (r_state != tsf_pkg::ST_ACCEPT);
    assign w_emit_load = (r_state == tsf_pkg::ST_EMIT) && (!r_o_valid || !i_stall);

    // Insertion chain: every cell compares against the incoming word in parallel.
    for (genvar j = 0; j < N; j++) begin : g_cell
        tsf_pkg::t_cell_ctl w_ctl;
        logic [B-1:0]       w_left_val;
        logic               w_left_gt;

        assign w_ctl.load   = w_in_acc;
        assign w_ctl.shift  = (r_state == tsf_pkg::ST_DRAIN);
        assign w_ctl.below  = (32'(w_eff_pos) > j);
        assign w_ctl.at_pos = (32'(w_eff_pos) == j);

        if (j == 0) begin : g_head
            assign w_left_val = '0;
            assign w_left_gt  = 1'b0;
        end else begin : g_body
            assign w_left_val = w_val[j-1];
            assign w_left_gt  = w_gt[j-1];
        end

        tsf_cell #(
            .SAMPLE_BITS (B)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_sample   (i_sample),
            .i_left_val (w_left_val),
            .i_left_gt  (w_left_gt),
            .o_val      (w_val[j]),
            .o_gt       (w_gt[j])
        );
    end

    tsf_div #(
        .NUM_W (NUM_W),
        .DEN_W (tsf_pkg::SCALE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_div_sat = (|w_div_quot[NUM_W-1:tsf_pkg::SCREEN_W]) ? '1
                                                               : w_div_quot[tsf_pkg::SCREEN_W-1:0];

    assign w_mean_prod = PROD_W'(r_sum) * PROD_W'(MEAN_MUL);

    // The tail of the chain leaves highest first; the window is symmetric.
    assign w_in_window = (32'(r_drn) >= 32'(TRIM_EACH_END)) &&
                         (32'(r_drn) <  32'(N - TRIM_EACH_END));

    assign w_dx    = (r_first_x > r_held_x) ? (r_first_x - r_held_x) : (r_held_x - r_first_x);
    assign w_dy    = (r_first_y > r_mean)   ? (r_first_y - r_mean)   : (r_mean - r_first_y);
    assign w_low   = (CW'(r_held_x) < CW'(r_min_valid)) || (CW'(r_mean) < CW'(r_min_valid));
    assign w_far   = (CW'(w_dx) >= CW'(r_agree_range)) || (CW'(w_dy) >= CW'(r_agree_range));
    assign w_x_sum = {1'b0, r_first_x} + {1'b0, r_held_x};
    assign w_y_sum = {1'b0, r_first_y} + {1'b0, r_mean};

    assign w_raw_sel = (r_state == tsf_pkg::ST_Y_GO) ? CW'(r_yr) : CW'(r_xr);
    assign w_off_sel = (r_state == tsf_pkg::ST_Y_GO) ? CW'(r_y_offset) : CW'(r_x_offset);
    assign w_dist    = (w_raw_sel > w_off_sel) ? (w_raw_sel - w_off_sel)
                                               : (w_off_sel - w_raw_sel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsf_pkg::ST_ACCEPT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = r_x_scale;
        case (r_state)
            tsf_pkg::ST_ACCEPT: begin
                if (w_in_acc && w_last_pos) begin
                    n_state = tsf_pkg::ST_DRAIN;
                end
            end
            tsf_pkg::ST_DRAIN: begin
                if (r_drn == PW'(N - 1)) begin
                    n_state = tsf_pkg::ST_MEAN;
                end
            end
            tsf_pkg::ST_MEAN: begin
                n_state = tsf_pkg::ST_DECIDE;
            end
            tsf_pkg::ST_DECIDE: begin
                case (r_group)
                    tsf_pkg::GRP_FIRST_Y: begin
                        n_state = w_low ? tsf_pkg::ST_EMIT : tsf_pkg::ST_ACCEPT;
                    end
                    tsf_pkg::GRP_SECOND_Y: begin
                        n_state = (w_low || w_far) ? tsf_pkg::ST_EMIT : tsf_pkg::ST_X_GO;
                    end
                    default: begin
                        n_state = tsf_pkg::ST_ACCEPT;
                    end
                endcase
            end
            tsf_pkg::ST_X_GO: begin
                w_div_start = 1'b1;
                w_div_num   = NUM_W'(w_dist) * NUM_W'(tsf_pkg::SCREEN_UNITS);
                w_div_den   = r_x_scale;
                n_state     = tsf_pkg::ST_X_WAIT;
            end
            tsf_pkg::ST_X_WAIT: begin
                if (w_div_done) begin
                    n_state = tsf_pkg::ST_Y_GO;
                end
            end
            tsf_pkg::ST_Y_GO: begin
                w_div_start = 1'b1;
                w_div_num   = NUM_W'(w_dist) * NUM_W'(tsf_pkg::SCREEN_UNITS);
                w_div_den   = r_y_scale;
                n_state     = tsf_pkg::ST_Y_WAIT;
            end
            tsf_pkg::ST_Y_WAIT: begin
                if (w_div_done) begin
                    n_state = tsf_pkg::ST_EMIT;
                end
            end
            tsf_pkg::ST_EMIT: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = tsf_pkg::ST_ACCEPT;
                end
            end
            default: begin
                n_state = tsf_pkg::ST_ACCEPT;
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_valid   <= tsf_pkg::MIN_VALID_RST;
            r_agree_range <= tsf_pkg::AGREE_RANGE_RST;
            r_x_offset    <= tsf_pkg::X_OFFSET_RST;
            r_y_offset    <= tsf_pkg::Y_OFFSET_RST;
            r_x_scale     <= tsf_pkg::X_SCALE_RST;
            r_y_scale     <= tsf_pkg::Y_SCALE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tsf_pkg::CFG_MIN_VALID:   r_min_valid   <= i_cfg_data[tsf_pkg::RAW_W-1:0];
                tsf_pkg::CFG_AGREE_RANGE: r_agree_range <= i_cfg_data[tsf_pkg::RAW_W-1:0];
                tsf_pkg::CFG_X_OFFSET:    r_x_offset    <= i_cfg_data[tsf_pkg::RAW_W-1:0];
                tsf_pkg::CFG_Y_OFFSET:    r_y_offset    <= i_cfg_data[tsf_pkg::RAW_W-1:0];
                tsf_pkg::CFG_X_SCALE:     r_x_scale     <= i_cfg_data;
                tsf_pkg::CFG_Y_SCALE:     r_y_scale     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencing and the held means.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_group   <= tsf_pkg::GRP_FIRST_X;
            r_drn     <= '0;
            r_held_x  <= '0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_group <= w_eff_group;
                r_pos   <= w_last_pos ? '0 : w_eff_pos + 1'b1;
                r_drn   <= '0;
            end
            if (r_state == tsf_pkg::ST_DRAIN) begin
                r_drn <= r_drn + 1'b1;
            end
            if (r_state == tsf_pkg::ST_DECIDE) begin
                case (r_group)
                    tsf_pkg::GRP_FIRST_Y: begin
                        if (w_low) begin
                            r_group <= tsf_pkg::GRP_FIRST_X;
                        end else begin
                            r_first_x <= r_held_x;
                            r_first_y <= r_mean;
                            r_group   <= tsf_pkg::GRP_SECOND_X;
                        end
                    end
                    tsf_pkg::GRP_SECOND_Y: begin
                        r_group <= tsf_pkg::GRP_FIRST_X;
                    end
                    default: begin
                        r_held_x <= r_mean;
                        r_group  <= r_group + 1'b1;
                    end
                endcase
            end
            if (w_emit_load) begin
                r_o_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Datapath payload.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sum <= '0;
        end else if ((r_state == tsf_pkg::ST_DRAIN) && w_in_window) begin
            r_sum <= r_sum + SUM_W'(w_val[N-1]);
        end
        if (r_state == tsf_pkg::ST_MEAN) begin
            r_mean <= w_mean_prod[MEAN_SH +: B];
        end
        if (r_state == tsf_pkg::ST_DECIDE) begin
            if ((r_group == tsf_pkg::GRP_SECOND_Y) && !w_low && !w_far) begin
                r_ok <= 1'b1;
                r_xr <= w_x_sum[B:1];
                r_yr <= w_y_sum[B:1];
            end else begin
                r_ok <= 1'b0;
                r_xr <= '0;
                r_yr <= '0;
                r_xs <= '0;
                r_ys <= '0;
            end
        end
        if ((r_state == tsf_pkg::ST_X_WAIT) && w_div_done) begin
            r_xs <= w_div_sat;
        end
        if ((r_state == tsf_pkg::ST_Y_WAIT) && w_div_done) begin
            r_ys <= w_div_sat;
        end
        if (w_emit_load) begin
            r_o_accepted <= r_ok;
            r_o_x_raw    <= tsf_pkg::RAW_W'(r_xr);
            r_o_y_raw    <= tsf_pkg::RAW_W'(r_yr);
            r_o_x_screen <= r_xs;
            r_o_y_screen <= r_ys;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_accepted = r_o_accepted;
    assign o_x_raw    = r_o_x_raw;
    assign o_y_raw    = r_o_y_raw;
    assign o_x_screen = r_o_x_screen;
    assign o_y_screen = r_o_y_screen;

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_accepted) |-> (o_x_raw == '0 && o_y_raw == '0 &&
                                      o_x_screen == '0 && o_y_screen == '0))
        else $error("rejected word carries nonzero coordinates");

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_busy)
        else $error("divider started while busy");

    a_group_end_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_last_pos) |=> (r_state == tsf_pkg::ST_DRAIN && o_stall))
        else $error("group end did not start the drain");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> ($past(r_state) == tsf_pkg::ST_EMIT))
        else $error("result appeared outside the emit step");

endmodule
